### hdl/pfm_pkg.sv
// shared types, constants and helpers of the pulse flow meter
`default_nettype none
package pfm_pkg;
	localparam int RING_DEPTH_DEF = 2;
	localparam logic [13:0] CALIB_MIN = 14'd100;
	localparam logic [13:0] CALIB_MAX = 14'd10000;

	typedef enum logic [1:0] {
		CMD_EDGE      = 2'd0,
		CMD_HEARTBEAT = 2'd1,
		CMD_CLEAR     = 2'd2,
		CMD_NONE      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_CALIB      = 3'd0,
		REG_DEBOUNCE   = 3'd1,
		REG_WINDOW     = 3'd2,
		REG_NOTE_STEP  = 3'd3,
		REG_NOTE_INT   = 3'd4,
		REG_EVAL_BATCH = 3'd5,
		REG_EVAL_INT   = 3'd6,
		REG_UNUSED     = 3'd7
	} reg_idx_t;

	// classified event handed from the front part to the back part
	typedef struct packed {
		logic        accepted;
		logic        evaluate;
		logic        clear;
		logic [31:0] now;
		logic [31:0] total;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RATE,
		BK_RWAIT,
		BK_MEAN,
		BK_MWAIT,
		BK_VOL,
		BK_VWAIT,
		BK_OUT
	} bk_state_t;
endpackage
`default_nettype wire

### hdl/pfm_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module pfm_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic [47:0]      quotient
);
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;

	assign trial    = {rem_q[31:0], quo_q[47]};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 6'd48;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### hdl/pfm_front.sv
// front part: debounce, pulse count and trigger decision
`default_nettype none
module pfm_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            in_cmd,
	input  wire logic [31:0]           in_now,
	input  wire logic [7:0]            deb_gap,
	input  wire logic [7:0]            eval_pulse_batch,
	input  wire logic [15:0]           eval_interval_ms,
	output logic                       job_valid,
	input  wire logic                  job_ready,
	output pfm_pkg::job_t              job
);
	logic [31:0] total_q, last_edge_q, cnt_trig_q, trig_time_q;
	logic        take, is_edge, pass, trig;
	logic [31:0] total_inc;
	pfm_pkg::job_t job_q;
	logic        jv_q;

	assign in_ready  = !jv_q || job_ready;
	assign take      = in_valid && in_ready;
	assign is_edge   = in_cmd == pfm_pkg::CMD_EDGE;
	assign pass      = (in_now - last_edge_q) > {24'd0, deb_gap};
	assign total_inc = total_q + 32'd1;
	assign trig      = ((total_inc - cnt_trig_q) >= {24'd0, eval_pulse_batch}) ||
		((in_now - trig_time_q) >= {16'd0, eval_interval_ms});
	assign job_valid = jv_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			last_edge_q <= '0;
			cnt_trig_q  <= '0;
			trig_time_q <= '0;
			jv_q        <= 1'b0;
		end else begin
			if (job_ready) begin
				jv_q <= 1'b0;
			end
			if (take) begin
				jv_q <= 1'b1;
				if (is_edge && pass) begin
					last_edge_q <= in_now;
					total_q     <= total_inc;
					if (trig) begin
						cnt_trig_q  <= total_inc;
						trig_time_q <= in_now;
					end
				end else if (in_cmd == pfm_pkg::CMD_CLEAR) begin
					total_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q.now      <= in_now;
			job_q.accepted <= is_edge && pass;
			job_q.evaluate <= (is_edge && pass && trig) ||
				(in_cmd == pfm_pkg::CMD_HEARTBEAT);
			job_q.clear    <= in_cmd == pfm_pkg::CMD_CLEAR;
			if (is_edge && pass) begin
				job_q.total <= total_inc;
			end else if (in_cmd == pfm_pkg::CMD_CLEAR) begin
				job_q.total <= '0;
			end else begin
				job_q.total <= total_q;
			end
		end
	end
endmodule
`default_nettype wire

### hdl/pfm_back.sv
// back part: rate window, smoothing, notify and volume
`default_nettype none
module pfm_back #(
	parameter int RING_DEPTH = pfm_pkg::RING_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	output logic                job_ready,
	input  wire pfm_pkg::job_t  job,
	input  wire logic [13:0]    cal_ppl,
	input  wire logic [15:0]    rate_window_ms,
	input  wire logic [15:0]    notify_pulse_step,
	input  wire logic [15:0]    notify_interval_ms,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [103:0]        out_data
);
	localparam int SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int NW = $clog2(RING_DEPTH + 1);

	pfm_pkg::bk_state_t state_q, state_d;
	pfm_pkg::job_t      job_q;
	logic [31:0] ring_q [RING_DEPTH];
	logic [SW-1:0] slot_q, slot_nxt;
	logic [31:0] smooth_q, win_t_q, win_c_q, note_c_q, note_t_q;
	logic        note_q, rate_go_q;
	logic [35:0] vol_q;
	logic [31:0] tdiff, pdiff;
	logic        win_due, push_zero, rate_go;
	logic        div_start, div_busy;
	logic [47:0] div_a, div_q;
	logic [31:0] div_b;
	logic [34:0] sum;
	logic [NW-1:0] nz;
	logic        out_v_q;
	logic [103:0] out_d_q;

	assign tdiff   = job_q.now - win_t_q;
	assign pdiff   = job_q.total - win_c_q;
	assign win_due = tdiff >= {16'd0, rate_window_ms};
	// rate division only for a due window with pulses over nonzero time
	assign rate_go   = job_q.evaluate && win_due && (pdiff != 32'd0) && (tdiff != 32'd0);
	// a due window with no new pulses pushes a zero rate
	assign push_zero = job_q.evaluate && win_due && (pdiff == 32'd0);
	assign slot_nxt  = (slot_q == SW'(RING_DEPTH - 1)) ? '0 : slot_q + SW'(1);

	always_comb begin
		sum = '0;
		nz  = '0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			if (ring_q[i] != 32'd0) begin
				sum = sum + {3'd0, ring_q[i]};
				nz  = nz + NW'(1);
			end
		end
	end

	pfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quotient (div_q)
	);

	assign job_ready = state_q == pfm_pkg::BK_IDLE;
	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pfm_pkg::BK_IDLE:  if (job_valid) state_d = pfm_pkg::BK_RATE;
			pfm_pkg::BK_RATE:  state_d = pfm_pkg::BK_RWAIT;
			pfm_pkg::BK_RWAIT: if (!div_busy) state_d = pfm_pkg::BK_MEAN;
			pfm_pkg::BK_MEAN:  state_d = pfm_pkg::BK_MWAIT;
			pfm_pkg::BK_MWAIT: if (!div_busy) state_d = pfm_pkg::BK_VOL;
			pfm_pkg::BK_VOL:   state_d = pfm_pkg::BK_VWAIT;
			pfm_pkg::BK_VWAIT: if (!div_busy) state_d = pfm_pkg::BK_OUT;
			pfm_pkg::BK_OUT:   if (!out_v_q || out_ready) state_d = pfm_pkg::BK_IDLE;
			default:           state_d = pfm_pkg::BK_IDLE;
		endcase
	end

	// divider operands per phase
	always_comb begin
		div_start = 1'b0;
		div_a     = '0;
		div_b     = 32'd1;
		case (state_q)
			pfm_pkg::BK_RATE: begin
				div_start = rate_go;
				// pulses times 1000 as 1024 - 32 + 8
				div_a = {6'd0, pdiff, 10'd0} - {11'd0, pdiff, 5'd0} +
					{13'd0, pdiff, 3'd0};
				div_b = tdiff;
			end
			pfm_pkg::BK_MEAN: begin
				div_start = nz > NW'(1);
				div_a     = {13'd0, sum};
				div_b     = {{(32-NW){1'b0}}, nz};
			end
			pfm_pkg::BK_VOL: begin
				div_start = 1'b1;
				div_a = {6'd0, job_q.total, 10'd0} - {11'd0, job_q.total, 5'd0} +
					{13'd0, job_q.total, 3'd0};
				div_b = {18'd0, cal_ppl};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pfm_pkg::BK_IDLE;
			slot_q   <= '0;
			smooth_q <= '0;
			win_t_q  <= '0;
			win_c_q  <= '0;
			note_c_q <= '0;
			note_t_q <= '0;
			note_q   <= 1'b0;
			out_v_q  <= 1'b0;
			for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (out_ready) out_v_q <= 1'b0;
			case (state_q)
				pfm_pkg::BK_RATE: begin
					note_q <= 1'b0;
					if (job_q.clear) begin
						smooth_q <= '0;
						slot_q   <= '0;
						for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
					end else if (push_zero) begin
						ring_q[slot_q] <= '0;
						slot_q         <= slot_nxt;
					end
					if (job_q.evaluate) begin
						if (win_due) begin
							win_t_q <= job_q.now;
							win_c_q <= job_q.total;
						end
						if ((job_q.total - note_c_q) >= {16'd0, notify_pulse_step} ||
							(job_q.now - note_t_q) >= {16'd0, notify_interval_ms}) begin
							note_q   <= 1'b1;
							note_c_q <= job_q.total;
							note_t_q <= job_q.now;
						end
					end
				end
				pfm_pkg::BK_RWAIT: begin
					// rate division done: push the saturated rate
					if (!div_busy && rate_go_q) begin
						ring_q[slot_q] <= (div_q[47:32] != 16'd0) ? 32'hFFFF_FFFF
							: div_q[31:0];
						slot_q <= slot_nxt;
					end
				end
				pfm_pkg::BK_MEAN: begin
					// zero or one nonzero entry needs no division
					if (nz <= NW'(1)) begin
						smooth_q <= (nz == NW'(1)) ? sum[31:0] : '0;
					end
				end
				pfm_pkg::BK_MWAIT: begin
					if (!div_busy && nz > NW'(1)) begin
						smooth_q <= div_q[31:0];
					end
				end
				pfm_pkg::BK_OUT: begin
					if (!out_v_q || out_ready) begin
						out_v_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pfm_pkg::BK_IDLE && job_valid) job_q <= job;
		if (state_q == pfm_pkg::BK_RATE) rate_go_q <= rate_go;
		if (state_q == pfm_pkg::BK_VWAIT && !div_busy) vol_q <= div_q[35:0];
		if (state_q == pfm_pkg::BK_OUT && (!out_v_q || out_ready)) begin
			out_d_q <= {1'b0, vol_q, smooth_q, note_q, job_q.evaluate,
				job_q.accepted, job_q.total};
		end
	end
endmodule
`default_nettype wire

### hdl/pulse_flow_meter_top.sv
// top level of the pulse flow meter: config registers, front, back
`default_nettype none
// Pulse flow meter. Each transfer on s_axis carries a command (edge,
// heartbeat, counter clear) and a millisecond timestamp and yields one
// result transfer on m_axis. The front part debounces and counts edges and
// parks the classified event in a one-entry job register; the back part
// runs a shared 48-step serial divider up to three times (rate, smoothing
// mean, volume). The volume division always runs, the rate and the mean
// division only when needed; the input takes the next item as soon as the
// back part picks up the parked one. A result that is not taken waits in
// the output register while the back part works on the next job. Register
// writes are meant for an idle block; a calibration outside 100..10000 is
// ignored.
module pulse_flow_meter_top #(
	parameter int RING_DEPTH = pfm_pkg::RING_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [39:0]  s_axis_tdata,   // command[1:0], now_ms[33:2], zero pad
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// total[31:0], accepted[32], evaluated[33], notify[34], rate[66:35],
	// volume[102:67], zero pad[103]
	output logic [103:0]      m_axis_tdata
);
	logic [13:0] calib_q;
	logic [7:0]  deb_q, batch_q;
	logic [15:0] win_q, nstep_q, nint_q, eint_q;
	logic        jv, jr;
	pfm_pkg::job_t job;
	logic [103:0] raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= 14'd450;
			deb_q   <= 8'd5;
			win_q   <= 16'd2000;
			nstep_q <= 16'd10;
			nint_q  <= 16'd5000;
			batch_q <= 8'd5;
			eint_q  <= 16'd3000;
		end else if (cfg_valid) begin
			case (pfm_pkg::reg_idx_t'(cfg_index))
				pfm_pkg::REG_CALIB: if (cfg_data[13:0] >= pfm_pkg::CALIB_MIN &&
					cfg_data[13:0] <= pfm_pkg::CALIB_MAX) calib_q <= cfg_data[13:0];
				pfm_pkg::REG_DEBOUNCE:   deb_q   <= cfg_data[7:0];
				pfm_pkg::REG_WINDOW:     win_q   <= cfg_data;
				pfm_pkg::REG_NOTE_STEP:  nstep_q <= cfg_data;
				pfm_pkg::REG_NOTE_INT:   nint_q  <= cfg_data;
				pfm_pkg::REG_EVAL_BATCH: batch_q <= cfg_data[7:0];
				pfm_pkg::REG_EVAL_INT:   eint_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pfm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(s_axis_tdata[1:0]), .in_now(s_axis_tdata[33:2]),
		.deb_gap(deb_q), .eval_pulse_batch(batch_q), .eval_interval_ms(eint_q),
		.job_valid(jv), .job_ready(jr), .job(job)
	);

	pfm_back #(.RING_DEPTH(RING_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(jv), .job_ready(jr), .job(job),
		.cal_ppl(calib_q), .rate_window_ms(win_q),
		.notify_pulse_step(nstep_q), .notify_interval_ms(nint_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(raw)
	);

	assign m_axis_tdata = raw;

	// a pending result must hold while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped");
	// a pending result keeps its data while stalled
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// notify only with evaluate
	a_note: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[34] || m_axis_tdata[33]))
		else $error("notify without evaluation");
endmodule
`default_nettype wire
